[rtl/status_led_pattern_sequencer_defines.svh]
// Assertion macros shared by the sequencer RTL.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH
`define STATUS_LED_PATTERN_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SLPS_ASSERT_NOW(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("invariant violated");

`define SLPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check violated");

`else

`define SLPS_ASSERT_NOW(lbl, expr)
`define SLPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/slps_pkg.sv]
package slps_pkg;

    localparam int unsigned PIXEL_COUNT = 7;
    localparam int unsigned RING_SIZE   = PIXEL_COUNT - 1;
    localparam logic [2:0]  LAST_PIX    = 3'(PIXEL_COUNT - 1);
    localparam logic [2:0]  SPIN_LAST   = 3'(RING_SIZE - 1);

    // timing in milliseconds
    localparam int unsigned BOOT_MS         = 2000;
    localparam int unsigned SPIN_GAP_MS     = 60;
    localparam int unsigned FAULT_GAP_MS    = 10;
    localparam int unsigned OPER_PERIOD_MS  = 1000;
    localparam int unsigned OPER_ON_MS      = 100;
    localparam int unsigned OPER_LOW_BEG_MS = 200;
    localparam int unsigned OPER_LOW_END_MS = 220;
    localparam int unsigned BRAKE_FLASH_MS  = 500;
    localparam int unsigned BRAKE_SLOT_MS   = 100;
    localparam int unsigned BRAKE_ON_MS     = 50;
    localparam int unsigned FAULT_BLINK_MS  = 125;

    // intensities
    localparam logic [7:0] LVL_FULL = 8'd255;
    localparam logic [7:0] LVL_LOW  = 8'd25;
    localparam logic [7:0] LVL_DIM  = 8'd38;

    // quarter-wave sine polynomial, Q30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [30:0] SIN_B = 31'd693598668;
    localparam logic [30:0] SIN_C = 31'd85569306;
    localparam logic [30:0] SIN_D = 31'd5026997;
    localparam logic [30:0] SIN_E = 31'd172273;

    // floor(v * 15 / 100) == (v * 78645) >> 19 for v up to 255
    localparam logic [16:0] LVL_SCALE_MUL   = 17'd78645;
    localparam int unsigned LVL_SCALE_SHIFT = 19;

    typedef enum logic [2:0] {
        ST_BOOT  = 3'd0,
        ST_BCAST = 3'd1,
        ST_CONN  = 3'd2,
        ST_OPER  = 3'd3,
        ST_BRAKE = 3'd4,
        ST_FAULT = 3'd5
    } t_state;

    // frame kind as classified at the front
    typedef enum logic [2:0] {
        K_BLANK,
        K_OPER,
        K_BRAKE,
        K_FAULT,
        K_BOOT,
        K_BCAST,
        K_CONN
    } t_kind;

    // frame kind as drawn at the back
    typedef enum logic [2:0] {
        F_SOLID,
        F_FAULT,
        F_BOOT,
        F_BCAST,
        F_CONN
    } t_fkind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] red;
        logic [2:0] step;
    } t_desc;

    typedef struct packed {
        t_fkind     kind;
        logic [7:0] lvl;
        logic [2:0] step;
        logic [7:0] brth;
    } t_frame;

    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pixel;

    function automatic logic [7:0] trail_level(input logic [2:0] pos);
        logic [7:0] lv;
        case (pos)
            3'd0:    lv = 8'd38;
            3'd1:    lv = 8'd13;
            3'd2:    lv = 8'd4;
            3'd3:    lv = 8'd2;
            3'd4:    lv = 8'd1;
            default: lv = 8'd0;
        endcase
        return lv;
    endfunction

endpackage

[rtl/status_led_pattern_sequencer.sv]
// Path: an accepted beat passes the front stage, the 17-stage arithmetic pipeline (modulo and
// sine units), a queue write and the output load before its first pixel beat leaves.
// Throughput: a frame leaves as seven pixel beats, one per cycle while m_axis_tready is high;
// input beats are taken every cycle while fewer than QUEUE_DEPTH frames are pending.
// Beats that give no frame are consumed and take no queue slot. Reset: synchronous, active low; shows
// the booting state, timers and spinner at zero, enable set, queue and pipeline empty.
module status_led_pattern_sequencer #(
    parameter int unsigned BREATHE_PERIOD = 2000,
    parameter int unsigned QUEUE_DEPTH    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: now_ms[31:0], connected[32], streaming[33], braking[34], fault[35],
    //        led_mode[43:36], zero pad[47:44]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // tdata: pixel_index[2:0], red[10:3], green[18:11], blue[26:19], zero pad[31:27]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slps_pkg::*;

    logic   r_enable;
    logic   f_vld, c_vld, q_empty, pop;
    t_desc  f_desc;
    logic [31:0] f_now;
    t_frame c_frame, q_frame;
    t_pixel pix;

    // enable register at byte address 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_enable <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {31'd0, r_enable};

    slps_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (r_enable),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_now       (s_axis_tdata[31:0]),
        .i_connected (s_axis_tdata[32]),
        .i_streaming (s_axis_tdata[33]),
        .i_braking   (s_axis_tdata[34]),
        .i_fault     (s_axis_tdata[35]),
        .i_led_mode  (s_axis_tdata[43:36]),
        .i_pop       (pop),
        .o_vld       (f_vld),
        .o_desc      (f_desc),
        .o_now       (f_now)
    );

    slps_calc #(
        .BREATHE_PERIOD (BREATHE_PERIOD)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_desc  (f_desc),
        .i_now   (f_now),
        .o_vld   (c_vld),
        .o_frame (c_frame)
    );

    slps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_vld),
        .i_data  (c_frame),
        .i_pop   (pop),
        .o_data  (q_frame),
        .o_empty (q_empty)
    );

    slps_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!q_empty),
        .i_frame  (q_frame),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_pixel  (pix)
    );

    assign m_axis_tdata = {5'd0, pix.blue, pix.green, pix.red, pix.idx};
    assign m_axis_tlast = pix.last;

endmodule

[rtl/slps_front.sv]
`include "status_led_pattern_sequencer_defines.svh"

module slps_front #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_enable,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  logic [31:0]     i_now,
    input  logic            i_connected,
    input  logic            i_streaming,
    input  logic            i_braking,
    input  logic            i_fault,
    input  logic [7:0]      i_led_mode,
    input  logic            i_pop,
    output logic            o_vld,
    output slps_pkg::t_desc o_desc,
    output logic [31:0]     o_now
);
    import slps_pkg::*;

    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BRAKE_SLOTS = BRAKE_FLASH_MS / BRAKE_SLOT_MS;

    t_state      r_state, n_state, ns;
    logic [31:0] r_frame_ms, n_frame_ms;
    logic [2:0]  r_step, n_step;
    logic [31:0] r_brake_ms, n_brake_ms;
    logic [CNT_W-1:0] r_pend, n_pend;
    logic        r_vld, n_vld;
    t_desc       r_desc, n_desc;
    logic [31:0] r_now;

    logic        accept, changed, emit, brake_dark;
    logic [31:0] eff_frame, brk_start, gap, dlt;
    logic [2:0]  eff_step;

    assign o_tready = (r_pend != CNT_W'(QUEUE_DEPTH));
    assign accept   = i_tvalid && o_tready;

    always_comb begin
        if (i_fault)                  ns = ST_FAULT;
        else if (i_braking)           ns = ST_BRAKE;
        else if (i_now < 32'(BOOT_MS)) ns = ST_BOOT;
        else if (!i_connected)        ns = ST_BCAST;
        else if (!i_streaming)        ns = ST_CONN;
        else                          ns = ST_OPER;

        changed   = (ns != r_state);
        eff_frame = changed ? '0 : r_frame_ms;
        eff_step  = changed ? '0 : r_step;
        brk_start = (changed && ns == ST_BRAKE) ? i_now : r_brake_ms;
        gap       = i_now - eff_frame;
        dlt       = i_now - brk_start;

        // dark half of each flash slot during the opening burst
        brake_dark = 1'b0;
        for (int j = 0; j < BRAKE_SLOTS; j++) begin
            if (dlt[8:0] >= 9'(j * BRAKE_SLOT_MS + BRAKE_ON_MS) &&
                dlt[8:0] <  9'((j + 1) * BRAKE_SLOT_MS)) begin
                brake_dark = 1'b1;
            end
        end
        brake_dark = brake_dark && (dlt < 32'(BRAKE_FLASH_MS));

        n_state    = r_state;
        n_frame_ms = r_frame_ms;
        n_step     = r_step;
        n_brake_ms = r_brake_ms;
        emit       = 1'b0;
        n_desc     = '{kind: K_BLANK, red: '0, step: '0};

        if (accept && i_enable) begin
            if (i_led_mode == '0) begin
                emit = 1'b1;
            end else begin
                n_state    = ns;
                n_frame_ms = eff_frame;
                n_step     = eff_step;
                n_brake_ms = brk_start;
                unique case (ns) inside
                    ST_OPER: begin
                        emit        = 1'b1;
                        n_desc.kind = K_OPER;
                    end
                    ST_BRAKE: begin
                        emit        = 1'b1;
                        n_desc.kind = K_BRAKE;
                        n_desc.red  = brake_dark ? '0 : LVL_FULL;
                    end
                    ST_FAULT: begin
                        if (gap >= 32'(FAULT_GAP_MS)) begin
                            emit        = 1'b1;
                            n_frame_ms  = i_now;
                            n_desc.kind = K_FAULT;
                        end
                    end
                    ST_BOOT, ST_BCAST, ST_CONN: begin
                        if (gap >= 32'(SPIN_GAP_MS)) begin
                            emit        = 1'b1;
                            n_frame_ms  = i_now;
                            n_step      = (eff_step == SPIN_LAST) ? '0 : eff_step + 3'd1;
                            n_desc.step = eff_step;
                            n_desc.kind = (ns == ST_BOOT)  ? K_BOOT :
                                          (ns == ST_BCAST) ? K_BCAST : K_CONN;
                        end
                    end
                    default: ;
                endcase
            end
        end

        n_vld  = accept && emit;
        n_pend = r_pend + CNT_W'(n_vld) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_BOOT;
            r_frame_ms <= '0;
            r_step     <= '0;
            r_brake_ms <= '0;
            r_pend     <= '0;
            r_vld      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_frame_ms <= n_frame_ms;
            r_step     <= n_step;
            r_brake_ms <= n_brake_ms;
            r_pend     <= n_pend;
            r_vld      <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_now  <= i_now;
    end

    assign o_vld  = r_vld;
    assign o_desc = r_desc;
    assign o_now  = r_now;

    `SLPS_ASSERT_NOW(a_pend_bound, r_pend <= CNT_W'(QUEUE_DEPTH))
    `SLPS_ASSERT_NEXT(a_emit_needs_accept, !(i_tvalid && o_tready), !r_vld)

endmodule

[rtl/slps_calc.sv]
module slps_calc #(
    parameter int unsigned BREATHE_PERIOD = 2000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  slps_pkg::t_desc  i_desc,
    input  logic [31:0]      i_now,
    output logic             o_vld,
    output slps_pkg::t_frame o_frame
);
    import slps_pkg::*;

    localparam int unsigned NSTAGE     = 17;
    localparam logic [31:0] OPER_K     = 32'(OPER_PERIOD_MS);
    localparam logic [31:0] OPER_RECIP = 32'((64'd1 << 32) / OPER_PERIOD_MS);
    localparam logic [31:0] PER32      = 32'(BREATHE_PERIOD);
    localparam logic [31:0] PER_RECIP  = 32'((64'd1 << 32) / BREATHE_PERIOD);
    localparam logic [30:0] HORNER_COEF [11:14] = '{SIN_D, SIN_C, SIN_B, SIN_A};

    logic        r_vld [1:NSTAGE];
    logic [31:0] r_now [1:5];
    t_desc       r_desc [1:3];
    t_frame      r_frm [4:NSTAGE];

    logic [31:0] r_qa, r_ma, r_qb, r_mb, r_num7, r_num8, r_mc;
    logic [9:0]  r_c;
    logic [15:0] r_k, r_qc7, r_qc8, r_t16;
    logic [14:0] r_x [10:14];
    logic [14:0] r_x2 [10:13];
    logic        r_neg [10:14];
    logic [30:0] r_acc [11:14];
    logic [16:0] r_bn;
    logic [7:0]  r_v, r_brth;

    logic [63:0] pa, pb, pc;
    logic [31:0] ra, rb, rc, num7;
    logic [14:0] xr;
    logic [29:0] xx;
    logic [30:0] h_in [11:14];
    logic [45:0] h_prod [11:14];
    logic [45:0] s_prod;
    logic [16:0] s_val, s_cl;
    logic [24:0] v_prod, l_prod;
    logic [8:0]  v9;
    logic        fault_odd;
    t_frame      frm4;

    always_comb begin
        // now mod 1000, reciprocal estimate then one correction
        pa = i_now * OPER_RECIP;
        ra = r_now[2] - r_ma;

        // now mod BREATHE_PERIOD
        pb = r_now[3] * PER_RECIP;
        rb = r_now[5] - r_mb;

        // turn = floor(k * 65536 / BREATHE_PERIOD)
        num7 = {r_k, 16'd0};
        pc   = num7 * PER_RECIP;
        rc   = r_num8 - r_mc;

        xr = r_t16[14] ? 15'(15'd16384 - {1'b0, r_t16[13:0]}) : {1'b0, r_t16[13:0]};
        xx = xr * xr;

        for (int j = 11; j <= 14; j++) begin
            h_in[j]   = (j == 11) ? SIN_E : r_acc[(j > 11) ? j - 1 : 11];
            h_prod[j] = r_x2[j - 1] * h_in[j];
        end

        s_prod = r_x[14] * r_acc[14];
        s_val  = 17'(s_prod >> 29);
        s_cl   = (s_val > 17'd32768) ? 17'd32768 : s_val;

        v_prod = r_bn * 8'd255;
        v9     = 9'(v_prod >> 16);
        l_prod = r_v * LVL_SCALE_MUL;

        // odd count of 125 ms slots within the second
        fault_odd = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (r_c >= 10'((2 * j + 1) * FAULT_BLINK_MS) &&
                r_c <  10'((2 * j + 2) * FAULT_BLINK_MS)) begin
                fault_odd = 1'b1;
            end
        end

        frm4 = '{kind: F_SOLID, lvl: '0, step: r_desc[3].step, brth: '0};
        unique case (r_desc[3].kind)
            K_BLANK: frm4.lvl = '0;
            K_OPER: begin
                if (r_c < 10'(OPER_ON_MS)) begin
                    frm4.lvl = LVL_FULL;
                end else if (r_c >= 10'(OPER_LOW_BEG_MS) && r_c < 10'(OPER_LOW_END_MS)) begin
                    frm4.lvl = LVL_LOW;
                end
            end
            K_BRAKE: frm4.lvl = r_desc[3].red;
            K_FAULT: begin
                frm4.kind = F_FAULT;
                frm4.lvl  = fault_odd ? '0 : LVL_DIM;
            end
            K_BOOT:  frm4.kind = F_BOOT;
            K_BCAST: frm4.kind = F_BCAST;
            K_CONN:  frm4.kind = F_CONN;
            default: frm4.kind = F_SOLID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 1; j <= NSTAGE; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else begin
            r_vld[1] <= i_vld;
            for (int j = 2; j <= NSTAGE; j++) begin
                r_vld[j] <= r_vld[j - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now[1] <= i_now;
        for (int j = 2; j <= 5; j++) begin
            r_now[j] <= r_now[j - 1];
        end
        r_desc[1] <= i_desc;
        r_desc[2] <= r_desc[1];
        r_desc[3] <= r_desc[2];
        r_frm[4]  <= frm4;
        for (int j = 5; j <= NSTAGE; j++) begin
            r_frm[j] <= r_frm[j - 1];
        end

        r_qa <= pa[63:32];
        r_ma <= r_qa * OPER_K;
        r_c  <= (ra >= OPER_K) ? 10'(ra - OPER_K) : 10'(ra);

        r_qb <= pb[63:32];
        r_mb <= r_qb * PER32;
        r_k  <= (rb >= PER32) ? 16'(rb - PER32) : 16'(rb);

        r_qc7  <= pc[47:32];
        r_num7 <= num7;
        r_qc8  <= r_qc7;
        r_num8 <= r_num7;
        r_mc   <= {16'd0, r_qc7} * PER32;
        r_t16  <= (rc >= PER32) ? r_qc8 + 16'd1 : r_qc8;

        r_x[10]   <= xr;
        r_x2[10]  <= 15'(xx >> 14);
        r_neg[10] <= r_t16[15];
        for (int j = 11; j <= 14; j++) begin
            r_x[j]   <= r_x[j - 1];
            r_neg[j] <= r_neg[j - 1];
            r_acc[j] <= HORNER_COEF[j] - 31'(h_prod[j] >> 14);
        end
        for (int j = 11; j <= 13; j++) begin
            r_x2[j] <= r_x2[j - 1];
        end

        r_bn   <= r_neg[14] ? 17'd32768 - s_cl : 17'd32768 + s_cl;
        r_v    <= (v9 > 9'd255) ? 8'hFF : v9[7:0];
        r_brth <= 8'(l_prod >> LVL_SCALE_SHIFT);
    end

    always_comb begin
        o_frame      = r_frm[NSTAGE];
        o_frame.brth = r_brth;
    end

    assign o_vld = r_vld[NSTAGE];

endmodule

[rtl/slps_fifo.sv]
`include "status_led_pattern_sequencer_defines.svh"

module slps_fifo #(
    parameter int unsigned DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slps_pkg::t_frame i_data,
    input  logic             i_pop,
    output slps_pkg::t_frame o_data,
    output logic             o_empty
);
    import slps_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             full;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    `SLPS_ASSERT_NOW(a_no_overflow, !(i_push && full))
    `SLPS_ASSERT_NOW(a_no_underflow, !(i_pop && o_empty))

endmodule

[rtl/slps_back.sv]
`include "status_led_pattern_sequencer_defines.svh"

module slps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  slps_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output slps_pkg::t_pixel o_pixel
);
    import slps_pkg::*;

    logic       r_busy, n_busy;
    logic [2:0] r_pix, n_pix;
    t_frame     r_frm;

    logic       beat, load;
    logic [3:0] t_raw, t_idx;
    logic [7:0] tl;

    assign beat  = r_busy && i_tready;
    assign load  = i_avail && (!r_busy || (beat && r_pix == LAST_PIX));
    assign o_pop = load;

    always_comb begin
        n_busy = r_busy;
        n_pix  = r_pix;
        if (load) begin
            n_busy = 1'b1;
            n_pix  = '0;
        end else if (beat) begin
            if (r_pix == LAST_PIX) begin
                n_busy = 1'b0;
            end else begin
                n_pix = r_pix + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pix  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pix  <= n_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_frm <= i_frame;
        end
    end

    // trail position behind the spinner head for ring pixel r_pix
    always_comb begin
        t_raw = 4'({1'b0, r_frm.step}) + 4'(PIXEL_COUNT) - 4'({1'b0, r_pix});
        t_idx = (t_raw >= 4'(RING_SIZE)) ? t_raw - 4'(RING_SIZE) : t_raw;
        tl    = trail_level(t_idx[2:0]);

        o_pixel = '{idx: r_pix, red: '0, green: '0, blue: '0, last: (r_pix == LAST_PIX)};
        unique case (r_frm.kind)
            F_SOLID: o_pixel.red = r_frm.lvl;
            F_FAULT: o_pixel.red = (r_pix == '0) ? r_frm.lvl : r_frm.brth;
            F_BOOT: begin
                if (r_pix == '0) begin
                    o_pixel.red   = r_frm.brth;
                    o_pixel.green = r_frm.brth;
                end else begin
                    o_pixel.red   = tl;
                    o_pixel.green = tl;
                    o_pixel.blue  = tl;
                end
            end
            F_BCAST: begin
                if (r_pix == '0) begin
                    o_pixel.green = r_frm.brth;
                end else begin
                    o_pixel.red   = tl;
                    o_pixel.green = tl;
                    o_pixel.blue  = tl;
                end
            end
            F_CONN: o_pixel.blue = (r_pix == '0) ? LVL_DIM : tl;
            default: o_pixel.red = '0;
        endcase
    end

    assign o_tvalid = r_busy;

    `SLPS_ASSERT_NEXT(a_pix_advance, beat && r_pix != LAST_PIX, r_pix == $past(r_pix) + 3'd1)

endmodule
